### sv/tdcref_pkg.sv
// Package: constants, register indexes and helpers for the TDC hit time block.
`default_nettype none
package tdcref_pkg;

    localparam int TIME_W = 36;
    localparam int WIDE_W = 39;

    localparam logic [6:0] REF_CHANNEL = 7'd104;
    localparam logic [7:0] MARKER_BYTE = 8'hFC;

    localparam logic [19:0] COARSE_PERIOD_RST = 20'd163840;
    localparam logic [15:0] FINE_BIN_RST      = 16'd1321;
    localparam logic [6:0]  FINE_OFFSET_RST   = 7'd4;

    typedef enum logic [1:0] {
        REG_COARSE_PERIOD = 2'd0,
        REG_FINE_BIN      = 2'd1,
        REG_FINE_OFFSET   = 2'd2
    } cfg_reg_t;

    localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
    localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

    // clamp a wide signed value to the 36-bit signed range
    function automatic logic signed [TIME_W-1:0] sat36(input logic signed [WIDE_W-1:0] v);
        logic signed [TIME_W-1:0] r;
        if (v > WIDE_W'(TIME_MAX))
        begin
            r = TIME_MAX;
        end
        else if (v < WIDE_W'(TIME_MIN))
        begin
            r = TIME_MIN;
        end
        else
        begin
            r = v[TIME_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/tdc_hit_time_reference_subtract.sv
// Top level: TDC hit word to time conversion with per-module reference subtraction.
`default_nettype none
// ---------------------------------------------------------------------------
// TDC hit time conversion with reference subtraction.
//
// Input beats (s_*) carry a module index and one 32-bit TDC hit word. Marker
// words (top byte 0xFC) are taken but produce no output beat. Every other
// word gives one output beat (m_*): time = coarse*period - (fine-offset)*bin
// in ns Q.16. Channel 104 is the module reference; its time is stored and
// sent out as an absolute time (m_tuser = 1). Other channels get time minus
// the stored reference, wrapped by 65536 coarse periods when negative.
//
// Pipeline: input register, product register, time register, result
// register; one beat is accepted every cycle unless the receiver stalls.
// The reference store is a 48 x 36 memory read in the product stage, with
// the write of the reference just ahead forwarded. Reset clears the
// pipeline valids, the per-module reference valid flops and the config
// registers; the store itself holds no reset (no clearing pass). When the
// receiver stalls the whole pipeline freezes and s_tready drops in the
// same cycle; the held result stays on m_tdata.
// Config writes are taken any cycle and are meant for an idle block.
// ---------------------------------------------------------------------------
module tdc_hit_time_reference_subtract
    import tdcref_pkg::*;
#(
    parameter int MODULE_COUNT = 48
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [19:0] cfg_wdata,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [5:0] module_index, [37:6] raw_word, zero pad
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [35:0] hit_time, [41:36] hit_module,
                                        // [48:42] hit_channel, [49] trailing_edge,
                                        // [50] no_reference, zero pad
    output logic             m_tuser    // [0] is_reference
);

    localparam int IDX_W = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;

    // config registers
    logic [19:0] coarse_period_reg;
    logic [15:0] fine_bin_reg;
    logic [6:0]  fine_offset_reg;

    // whole pipeline moves together unless the result is stuck
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // input fields
    logic [5:0]  in_module;
    logic [31:0] in_word;
    logic        in_marker;
    assign in_module = s_tdata[5:0];
    assign in_word   = s_tdata[37:6];
    assign in_marker = (in_word[31:24] == MARKER_BYTE);

    // stage 1: decoded input
    logic        s1_valid_reg;
    logic [5:0]  s1_module_reg;
    logic [6:0]  s1_channel_reg;
    logic [15:0] s1_coarse_reg;
    logic [6:0]  s1_fine_reg;
    logic        s1_edge_reg;

    // stage 2: products
    logic                    s2_valid_reg;
    logic [TIME_W-1:0]       s2_p1_reg;
    logic signed [24:0]      s2_p2_reg;
    logic [5:0]              s2_module_reg;
    logic [6:0]              s2_channel_reg;
    logic                    s2_edge_reg;
    logic                    s2_ref_reg;
    logic                    s2_in_range_reg;
    logic [IDX_W-1:0]        s2_idx_reg;

    // stage 3: saturated time, reference lookup
    logic                    s3_valid_reg;
    logic signed [TIME_W-1:0] s3_time_reg;
    logic [5:0]              s3_module_reg;
    logic [6:0]              s3_channel_reg;
    logic                    s3_edge_reg;
    logic                    s3_ref_reg;
    logic                    s3_in_range_reg;
    logic [IDX_W-1:0]        s3_idx_reg;
    logic                    s3_have_ref_reg;
    logic                    s3_fwd_reg;
    logic signed [TIME_W-1:0] s3_fwd_time_reg;
    logic signed [TIME_W-1:0] s3_mem_q_reg;

    // reference store
    logic signed [TIME_W-1:0] ref_mem [MODULE_COUNT];
    logic [MODULE_COUNT-1:0]  ref_valid_reg;

    // output register
    logic                    out_valid_reg;
    logic signed [TIME_W-1:0] out_time_reg;
    logic [5:0]              out_module_reg;
    logic [6:0]              out_channel_reg;
    logic                    out_ref_reg;
    logic                    out_edge_reg;
    logic                    out_noref_reg;

    // ---------------- stage 1 -> 2 ----------------
    logic signed [7:0]       fine_diff;
    logic signed [16:0]      bin_s;
    logic [TIME_W-1:0]       p1_next;
    logic signed [24:0]      p2_next;
    logic [8:0]              mod_ext1;
    logic                    in_range_next;
    logic [IDX_W-1:0]        idx_next;

    always_comb
    begin
        fine_diff     = $signed({1'b0, s1_fine_reg}) - $signed({1'b0, fine_offset_reg});
        bin_s         = $signed({1'b0, fine_bin_reg});
        p1_next       = {20'b0, s1_coarse_reg} * {16'b0, coarse_period_reg};
        p2_next       = 25'(fine_diff) * 25'(bin_s);
        mod_ext1      = {3'b0, s1_module_reg};
        in_range_next = (mod_ext1 < 9'(MODULE_COUNT));
        idx_next      = mod_ext1[IDX_W-1:0];
    end

    // ---------------- stage 2 -> 3 ----------------
    logic signed [WIDE_W-1:0] t_wide;
    logic signed [TIME_W-1:0] t_next;
    logic                     ref_we;
    logic                     fwd_next;
    logic                     have_ref_next;

    always_comb
    begin
        t_wide        = $signed({3'b0, s2_p1_reg}) - WIDE_W'(s2_p2_reg);
        t_next        = sat36(t_wide);
        // reference in stage 3 writes the store on this edge
        ref_we        = adv && s3_valid_reg && s3_ref_reg && s3_in_range_reg;
        fwd_next      = ref_we && (s3_idx_reg == s2_idx_reg);
        have_ref_next = s2_in_range_reg && (fwd_next || ref_valid_reg[s2_idx_reg]);
    end

    // ---------------- stage 3 -> out ----------------
    logic signed [TIME_W-1:0] r_sel;
    logic signed [WIDE_W-1:0] d1;
    logic signed [WIDE_W-1:0] d2;
    logic signed [WIDE_W-1:0] d_sel;
    logic signed [TIME_W-1:0] res_time;

    always_comb
    begin
        r_sel = '0;
        if (s3_have_ref_reg)
        begin
            r_sel = s3_fwd_reg ? s3_fwd_time_reg : s3_mem_q_reg;
        end
        d1    = WIDE_W'(s3_time_reg) - WIDE_W'(r_sel);
        d2    = d1 + $signed({3'b0, coarse_period_reg, 16'b0});
        d_sel = d1[WIDE_W-1] ? d2 : d1;
        res_time = s3_ref_reg ? s3_time_reg : sat36(d_sel);
    end

    // ---------------- control state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coarse_period_reg <= COARSE_PERIOD_RST;
            fine_bin_reg      <= FINE_BIN_RST;
            fine_offset_reg   <= FINE_OFFSET_RST;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            s3_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            ref_valid_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_COARSE_PERIOD: coarse_period_reg <= cfg_wdata;
                    REG_FINE_BIN:      fine_bin_reg      <= cfg_wdata[15:0];
                    REG_FINE_OFFSET:   fine_offset_reg   <= cfg_wdata[6:0];
                    default:           ;
                endcase
            end
            if (adv)
            begin
                s1_valid_reg  <= s_tvalid && !in_marker;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
            if (ref_we)
            begin
                ref_valid_reg[s3_idx_reg] <= 1'b1;
            end
        end
    end

    // ---------------- payload and store ----------------
    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[s3_idx_reg] <= s3_time_reg;
        end
        if (adv)
        begin
            s1_module_reg   <= in_module;
            s1_channel_reg  <= in_word[30:24];
            s1_coarse_reg   <= in_word[23:8];
            s1_fine_reg     <= in_word[6:0];
            s1_edge_reg     <= in_word[31];

            s2_p1_reg       <= p1_next;
            s2_p2_reg       <= p2_next;
            s2_module_reg   <= s1_module_reg;
            s2_channel_reg  <= s1_channel_reg;
            s2_edge_reg     <= s1_edge_reg;
            s2_ref_reg      <= (s1_channel_reg == REF_CHANNEL);
            s2_in_range_reg <= in_range_next;
            s2_idx_reg      <= idx_next;

            s3_time_reg     <= t_next;
            s3_module_reg   <= s2_module_reg;
            s3_channel_reg  <= s2_channel_reg;
            s3_edge_reg     <= s2_edge_reg;
            s3_ref_reg      <= s2_ref_reg;
            s3_in_range_reg <= s2_in_range_reg;
            s3_idx_reg      <= s2_idx_reg;
            s3_have_ref_reg <= have_ref_next;
            s3_fwd_reg      <= fwd_next;
            s3_fwd_time_reg <= s3_time_reg;
            s3_mem_q_reg    <= ref_mem[s2_idx_reg];

            out_time_reg    <= res_time;
            out_module_reg  <= s3_module_reg;
            out_channel_reg <= s3_channel_reg;
            out_ref_reg     <= s3_ref_reg;
            out_edge_reg    <= s3_ref_reg ? 1'b0 : s3_edge_reg;
            out_noref_reg   <= s3_ref_reg ? 1'b0 : !s3_have_ref_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_noref_reg, out_edge_reg, out_channel_reg,
                       out_module_reg, out_time_reg};
    assign m_tuser  = out_ref_reg;

endmodule
`default_nettype wire
